>>> rtl/sravg_pkg.sv
// Shared constants and control types for the scaled running average unit.
// No dependencies; used by every other file of the block.
package sravg_pkg;

  localparam int ChanBits      = 3;
  localparam int SampleInBits  = 12;
  localparam int ScaleBits     = 16;
  localparam int TotalBits     = 32;
  localparam int AvgBits       = 28;
  localparam int ProductBits   = TotalBits + ScaleBits;

  localparam int NumChannelsDef = 8;
  localparam int CountBitsDef   = 20;
  localparam int SampleBitsDef  = 12;

  localparam int CfgIndexBits = 1;
  localparam logic [CfgIndexBits-1:0] RegAudioScale = 1'd0;
  localparam logic [CfgIndexBits-1:0] RegOtherScale = 1'd1;

  localparam logic [ScaleBits-1:0] AudioScaleReset = 16'd256;
  localparam logic [ScaleBits-1:0] OtherScaleReset = 16'd256;

  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  typedef struct packed {
    logic upd;
    logic clr;
  } st_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/sravg_if.sv
// Valid/ready channel interfaces for the sample input and the average output.
// Depends on sravg_pkg for field widths.
interface sravg_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [sravg_pkg::ChanBits-1:0]     channel;
  logic [sravg_pkg::SampleInBits-1:0] sample_value;

  modport source (output valid, op, channel, sample_value, input ready);
  modport sink (input valid, op, channel, sample_value, output ready);
endinterface

interface sravg_out_if;
  logic                          valid;
  logic                          ready;
  logic [sravg_pkg::ChanBits-1:0] out_channel;
  logic [sravg_pkg::AvgBits-1:0]  scaled_average;
  logic                          overflow;

  modport source (output valid, out_channel, scaled_average, overflow, input ready);
  modport sink (input valid, out_channel, scaled_average, overflow, output ready);
endinterface

>>> rtl/sravg_store.sv
// Per-channel running total, sample count and clear mark, with the update rule.
// Depends on sravg_pkg for widths and the command struct.
module sravg_store #(
  parameter int NUM_CHANNELS = sravg_pkg::NumChannelsDef,
  parameter int COUNT_BITS   = sravg_pkg::CountBitsDef,
  parameter int SAMPLE_BITS  = sravg_pkg::SampleBitsDef,
  parameter int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sravg_pkg::st_cmd_t             cmd,
  input  logic [CH_IDX_W-1:0]            idx,
  input  logic [SAMPLE_BITS-1:0]         sample,
  output logic [sravg_pkg::TotalBits-1:0] total,
  output logic [COUNT_BITS-1:0]          tally,
  output logic                           ovf
);
  import sravg_pkg::*;

  logic [TotalBits-1:0]  running_total [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] sample_tally  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] clear_pending;

  logic [TotalBits-1:0]  cur_total;
  logic [COUNT_BITS-1:0] cur_tally;

  always_comb begin
    cur_total = clear_pending[idx] ? '0 : running_total[idx];
    cur_tally = clear_pending[idx] ? '0 : sample_tally[idx];
    ovf       = (cur_tally == {COUNT_BITS{1'b1}});
    total     = ovf ? cur_total : cur_total + TotalBits'(sample);
    tally     = ovf ? cur_tally : cur_tally + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        running_total[i] <= '0;
        sample_tally[i]  <= '0;
      end
      clear_pending <= '0;
    end else if (cmd.upd) begin
      running_total[idx] <= total;
      sample_tally[idx]  <= tally;
      clear_pending[idx] <= 1'b0;
    end else if (cmd.clr) begin
      clear_pending[idx] <= 1'b1;
    end
  end

endmodule

>>> rtl/sravg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sravg_pkg for the status struct.
module sravg_div #(
  parameter int DIVIDEND_W = sravg_pkg::ProductBits,
  parameter int DIVISOR_W  = sravg_pkg::CountBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output sravg_pkg::div_stat_t  stat,
  output logic [DIVIDEND_W-1:0] quotient
);
  import sravg_pkg::*;

  localparam int CntW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CntW-1:0]       cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DIVIDEND_W - 1);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_W-2:0], ge};
        rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        cnt <= cnt - CntW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> rtl/scaled_running_average_per_channel_unit.sv
// Scaled running average per converter channel: top level and sequencer.
// Depends on sravg_pkg, sravg_if, sravg_store and sravg_div.
//
// Usage:
//   samples: input beats carry op, channel and sample_value. A sample beat
//     adds to its channel and yields one result beat with the channel,
//     total*scale/count and the overflow flag. A clear beat marks the channel
//     so its next sample restarts the average; it yields no result. A beat
//     for a channel beyond the configured count is dropped.
//   results: one output register; a held result does not block the next
//     input beat, only the hand-off of the following result.
//   cfg_we/cfg_index/cfg_data: scale writes, audio scale for channel zero,
//     other scale for the rest. Write only while idle.
// Sequence: an update step with the 32x16 multiply, a load step, the
//   one-bit-per-cycle divider, a step to see it finish and an output step
//   that waits while a held result is not yet taken. A clear beat ends
//   after the update step; a dropped beat leaves the sequencer idle.
// Flow: one shared divider; no new sample enters while one is in work; ready is
//   low while an item is in work and while a finished result waits for a
//   stalled receiver.
// Reset: totals, counts and clear marks go to zero, scales to 256.
module scaled_running_average_per_channel_unit #(
  parameter int NUM_CHANNELS = sravg_pkg::NumChannelsDef,
  parameter int COUNT_BITS   = sravg_pkg::CountBitsDef,
  parameter int SAMPLE_BITS  = sravg_pkg::SampleBitsDef
) (
  input  logic                                 clk,
  input  logic                                 rst,
  sravg_in_if.sink                             samples,
  sravg_out_if.source                          results,
  input  logic                                 cfg_we,
  input  logic [sravg_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [sravg_pkg::ScaleBits-1:0]      cfg_data
);
  import sravg_pkg::*;

  localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_UPD, S_START, S_DIV, S_DONE} state_t;

  state_t state;

  logic [ScaleBits-1:0] audio_scale;
  logic [ScaleBits-1:0] other_scale;

  logic                   op_q;
  logic [ChanBits-1:0]    chan_q;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [ProductBits-1:0] prod_q;
  logic [COUNT_BITS-1:0]  tally_q;
  logic                   ovf_q;

  logic                   out_valid;
  logic [ChanBits-1:0]    out_chan;
  logic [AvgBits-1:0]     out_avg;
  logic                   out_ovf;

  st_cmd_t                st_cmd;
  logic [ChIdxW-1:0]      st_idx;
  logic [TotalBits-1:0]   st_total;
  logic [COUNT_BITS-1:0]  st_tally;
  logic                   st_ovf;

  div_stat_t              div_stat;
  logic                   div_start;
  logic [ProductBits-1:0] quotient;

  logic [ScaleBits-1:0]   scale_sel;
  logic [ProductBits-1:0] mul_res;
  logic                   in_range;

  assign in_range  = (32'(samples.channel) < 32'(NUM_CHANNELS));
  assign st_idx    = ChIdxW'(chan_q);
  assign st_cmd.upd = (state == S_UPD) && (op_q == OpSample);
  assign st_cmd.clr = (state == S_UPD) && (op_q == OpClear);
  assign scale_sel = (chan_q == '0) ? audio_scale : other_scale;
  assign mul_res   = ProductBits'(st_total) * ProductBits'(scale_sel);
  assign div_start = (state == S_START);

  sravg_store #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_BITS(COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CH_IDX_W(ChIdxW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .cmd(st_cmd),
    .idx(st_idx),
    .sample(samp_q),
    .total(st_total),
    .tally(st_tally),
    .ovf(st_ovf)
  );

  sravg_div #(
    .DIVIDEND_W(ProductBits),
    .DIVISOR_W(COUNT_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(prod_q),
    .divisor(tally_q),
    .stat(div_stat),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_scale <= AudioScaleReset;
      other_scale <= OtherScaleReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegAudioScale: audio_scale <= cfg_data;
        RegOtherScale: other_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (results.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid && in_range) begin
            op_q   <= samples.op;
            chan_q <= samples.channel;
            samp_q <= SAMPLE_BITS'(samples.sample_value);
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          if (op_q == OpClear) begin
            state <= S_IDLE;
          end else begin
            prod_q  <= mul_res;
            tally_q <= st_tally;
            ovf_q   <= st_ovf;
            state   <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_chan  <= chan_q;
            out_avg   <= (tally_q == '0) ? '0 : quotient[AvgBits-1:0];
            out_ovf   <= ovf_q;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samples.ready          = (state == S_IDLE);
  assign results.valid          = out_valid;
  assign results.out_channel    = out_chan;
  assign results.scaled_average = out_avg;
  assign results.overflow       = out_ovf;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside divide phase");

  a_tally_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (tally_q != '0))
    else $error("divide started with zero count");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_stat.busy)
    else $error("divider did not start");
`endif

endmodule
